### sv/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame parser package
// Shared sizes, byte codes, transaction structs and the payload buffer
// address mapping used by the front parser, the queue and the drain engine.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Number of receive ports and payload bytes buffered per port.
  localparam int Ports       = 2;
  localparam int BufferDepth = 64;

  // Width of length and count fields (holds 0..BufferDepth).
  localparam int LenW = 7;

  // Payload buffer geometry: one region of BufferDepth bytes per port.
  localparam int MemDepth = Ports * BufferDepth;
  localparam int MemAW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  // Frame descriptor queue between the front and back parts.
  localparam int DescDepth = 2;
  localparam int QAW       = (DescDepth > 1) ? $clog2(DescDepth) : 1;

  // Command byte codes.
  localparam logic [7:0] CmdF1 = 8'hF1;
  localparam logic [7:0] CmdF2 = 8'hF2;

  // Configuration register indexes and reset values.
  localparam logic RegHead = 1'b0;
  localparam logic RegEnd  = 1'b1;
  localparam logic [7:0] HeadReset = 8'hAA;
  localparam logic [7:0] EndReset  = 8'h55;

  // A frame that passed its checksum, ready to be drained.
  typedef struct packed {
    logic            port;
    logic            cmd;
    logic [LenW-1:0] len;
  } sfp_desc_t;

  // One payload buffer write.
  typedef struct packed {
    logic             en;
    logic [MemAW-1:0] addr;
    logic [7:0]       data;
  } sfp_wr_t;

  // End of delivery for one port.
  typedef struct packed {
    logic valid;
    logic port;
  } sfp_done_t;

  // Buffer address of byte idx in the region of a port.
  function automatic logic [MemAW-1:0] sfp_addr(logic port, logic [LenW-1:0] idx);
    logic [MemAW-1:0] base;
    base = MemAW'(port) * MemAW'(BufferDepth);
    return base + MemAW'(idx);
  endfunction

endpackage

### sv/sfp_payload_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Payload buffer
// Holds the payload bytes of every port; one write port for the parser and
// one registered read port for the drain engine.
// ----------------------------------------------------------------------------
module sfp_payload_buf (
  input  logic                     clk_i,
  input  sfp_pkg::sfp_wr_t         wr_i,
  input  logic                     rd_en_i,
  input  logic [sfp_pkg::MemAW-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);

  logic [7:0] mem_q [sfp_pkg::MemDepth];
  logic [7:0] rd_data_q;

  // Write from the parser, registered read for the drain engine.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/sfp_desc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame descriptor queue
// Short FIFO of checked frames between the parser and the drain engine.
// ----------------------------------------------------------------------------
module sfp_desc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfp_pkg::sfp_desc_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output sfp_pkg::sfp_desc_t pop_data_o
);

  sfp_pkg::sfp_desc_t      entry_q [sfp_pkg::DescDepth];
  logic [sfp_pkg::QAW-1:0] wptr_q, wptr_d;
  logic [sfp_pkg::QAW-1:0] rptr_q, rptr_d;
  logic [sfp_pkg::QAW:0]   count_q, count_d;
  logic                    do_push, do_pop;

  assign full_o     = (count_q == (sfp_pkg::QAW+1)'(sfp_pkg::DescDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == sfp_pkg::QAW'(sfp_pkg::DescDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == sfp_pkg::QAW'(sfp_pkg::DescDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### sv/sfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser front end
// Runs one frame parser per port, writes payload bytes to the buffer and
// queues a descriptor for every frame whose checksum matches.
// ----------------------------------------------------------------------------
module sfp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [7:0]                head_byte_i,
  input  logic [7:0]                end_byte_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_port_i,
  input  logic [7:0]                in_byte_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output sfp_pkg::sfp_desc_t        desc_o,
  output sfp_pkg::sfp_wr_t          wr_o,
  input  sfp_pkg::sfp_done_t        done_i,
  output logic [sfp_pkg::Ports-1:0] busy_o
);

  localparam logic [2:0] StHead  = 3'd0;
  localparam logic [2:0] StCmd   = 3'd1;
  localparam logic [2:0] StLen   = 3'd2;
  localparam logic [2:0] StData  = 3'd3;
  localparam logic [2:0] StCheck = 3'd4;
  localparam logic [2:0] StEnd   = 3'd5;

  localparam int LenW = sfp_pkg::LenW;

  logic [2:0]      step_q   [sfp_pkg::Ports];
  logic [2:0]      step_d   [sfp_pkg::Ports];
  logic [LenW-1:0] count_q  [sfp_pkg::Ports];
  logic [LenW-1:0] count_d  [sfp_pkg::Ports];
  logic [LenW-1:0] flen_q   [sfp_pkg::Ports];
  logic [LenW-1:0] flen_d   [sfp_pkg::Ports];
  logic [7:0]      xsum_q   [sfp_pkg::Ports];
  logic [7:0]      xsum_d   [sfp_pkg::Ports];
  logic [7:0]      rcheck_q [sfp_pkg::Ports];
  logic [7:0]      rcheck_d [sfp_pkg::Ports];
  logic            cmd_q    [sfp_pkg::Ports];
  logic            cmd_d    [sfp_pkg::Ports];
  logic [sfp_pkg::Ports-1:0] busy_q, busy_d;

  logic            port_ok;
  logic            accept;
  logic            p;
  logic [LenW-1:0] cnt_next;

  assign p       = in_port_i;
  assign port_ok = (sfp_pkg::Ports > 1) || !in_port_i;

  // A port with a frame still in delivery takes no new bytes.
  assign in_ready_o = !q_full_i && !(port_ok && busy_q[p]);
  assign accept     = in_valid_i && in_ready_o;
  assign busy_o     = busy_q;
  assign cnt_next   = count_q[p] + 1'b1;

  // Parser step for the port of the accepted transaction.
  always_comb begin
    step_d   = step_q;
    count_d  = count_q;
    flen_d   = flen_q;
    xsum_d   = xsum_q;
    rcheck_d = rcheck_q;
    cmd_d    = cmd_q;
    push_o   = 1'b0;
    desc_o   = '{port: p, cmd: cmd_q[p], len: flen_q[p]};
    wr_o     = '{en: 1'b0, addr: sfp_pkg::sfp_addr(p, count_q[p]), data: in_byte_i};

    if (accept && port_ok) begin
      unique case (step_q[p])
        StHead: begin
          if (in_byte_i == head_byte_i) begin
            count_d[p]  = '0;
            flen_d[p]   = '0;
            xsum_d[p]   = '0;
            rcheck_d[p] = '0;
            cmd_d[p]    = 1'b0;
            step_d[p]   = StCmd;
          end
        end
        StCmd: begin
          priority if (in_byte_i == sfp_pkg::CmdF1 || in_byte_i == sfp_pkg::CmdF2) begin
            cmd_d[p]  = (in_byte_i == sfp_pkg::CmdF2);
            step_d[p] = StLen;
          end else if (in_byte_i == head_byte_i) begin
            step_d[p] = StCmd;
          end else begin
            step_d[p] = StHead;
          end
        end
        StLen: begin
          if (in_byte_i > 8'(sfp_pkg::BufferDepth)) begin
            step_d[p] = StHead;
          end else begin
            flen_d[p] = in_byte_i[LenW-1:0];
            step_d[p] = (in_byte_i == 8'h00) ? StEnd : StData;
          end
        end
        StData: begin
          if (count_q[p] < LenW'(sfp_pkg::BufferDepth)) begin
            wr_o.en    = 1'b1;
            xsum_d[p]  = xsum_q[p] ^ in_byte_i;
            count_d[p] = cnt_next;
            if (cnt_next >= flen_q[p]) begin
              step_d[p] = StCheck;
            end
          end else if (count_q[p] >= flen_q[p]) begin
            step_d[p] = StCheck;
          end
        end
        StCheck: begin
          rcheck_d[p] = in_byte_i;
          step_d[p]   = StEnd;
        end
        StEnd: begin
          if (in_byte_i == head_byte_i) begin
            count_d[p]  = '0;
            flen_d[p]   = '0;
            xsum_d[p]   = '0;
            rcheck_d[p] = '0;
            cmd_d[p]    = 1'b0;
            step_d[p]   = StCmd;
          end else begin
            push_o    = (in_byte_i == end_byte_i) && (xsum_q[p] == rcheck_q[p]);
            step_d[p] = StHead;
          end
        end
        default: begin
          step_d[p] = StHead;
        end
      endcase
    end
  end

  // Busy marks a port whose frame waits in the queue or is being drained.
  always_comb begin
    busy_d = busy_q;
    if (done_i.valid) begin
      busy_d[done_i.port] = 1'b0;
    end
    if (push_o) begin
      busy_d[p] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sfp_pkg::Ports; i++) begin
        step_q[i]   <= StHead;
        count_q[i]  <= '0;
        flen_q[i]   <= '0;
        xsum_q[i]   <= '0;
        rcheck_q[i] <= '0;
        cmd_q[i]    <= 1'b0;
      end
      busy_q <= '0;
    end else begin
      step_q   <= step_d;
      count_q  <= count_d;
      flen_q   <= flen_d;
      xsum_q   <= xsum_d;
      rcheck_q <= rcheck_d;
      cmd_q    <= cmd_d;
      busy_q   <= busy_d;
    end
  end

endmodule

### sv/sfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame drain engine
// Takes checked frames from the queue and sends their payload out one byte
// per transaction through an output register.
// ----------------------------------------------------------------------------
module sfp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  sfp_pkg::sfp_desc_t        desc_i,
  output logic                      pop_o,
  output logic                      rd_en_o,
  output logic [sfp_pkg::MemAW-1:0] rd_addr_o,
  input  logic [7:0]                rd_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      out_port_o,
  output logic                      out_command_o,
  output logic [sfp_pkg::LenW-1:0]  out_length_o,
  output logic [7:0]                out_byte_o,
  output logic                      out_last_o,
  output logic                      out_empty_o,
  output sfp_pkg::sfp_done_t        done_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StSend = 2'd2;

  logic [1:0]               state_q, state_d;
  sfp_pkg::sfp_desc_t       desc_q, desc_d;
  logic [sfp_pkg::LenW-1:0] idx_q, idx_d;
  logic [7:0]               byte_q, byte_d;
  logic                     last_q, last_d;
  logic                     empty_q, empty_d;
  logic [sfp_pkg::LenW-1:0] idx_next;

  assign idx_next = idx_q + 1'b1;

  // Drain sequencer: fetch a byte, load the output register, wait for the taker.
  always_comb begin
    state_d   = state_q;
    desc_d    = desc_q;
    idx_d     = idx_q;
    byte_d    = byte_q;
    last_d    = last_q;
    empty_d   = empty_q;
    pop_o     = 1'b0;
    rd_en_o   = 1'b0;
    rd_addr_o = sfp_pkg::sfp_addr(desc_q.port, idx_next);
    done_o    = '{valid: 1'b0, port: desc_q.port};

    unique case (state_q)
      StIdle: begin
        rd_addr_o = sfp_pkg::sfp_addr(desc_i.port, '0);
        if (q_valid_i) begin
          pop_o  = 1'b1;
          desc_d = desc_i;
          idx_d  = '0;
          if (desc_i.len == '0) begin
            byte_d  = 8'h00;
            last_d  = 1'b1;
            empty_d = 1'b1;
            state_d = StSend;
          end else begin
            rd_en_o = 1'b1;
            state_d = StLoad;
          end
        end
      end
      StLoad: begin
        byte_d  = rd_data_i;
        last_d  = (idx_next == desc_q.len);
        empty_d = 1'b0;
        state_d = StSend;
      end
      StSend: begin
        if (out_ready_i) begin
          if (last_q) begin
            done_o.valid = 1'b1;
            state_d      = StIdle;
          end else begin
            idx_d   = idx_next;
            rd_en_o = 1'b1;
            state_d = StLoad;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    desc_q  <= desc_d;
    idx_q   <= idx_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
    empty_q <= empty_d;
  end

  assign out_valid_o   = (state_q == StSend);
  assign out_port_o    = desc_q.port;
  assign out_command_o = desc_q.cmd;
  assign out_length_o  = desc_q.len;
  assign out_byte_o    = byte_q;
  assign out_last_o    = last_q;
  assign out_empty_o   = empty_q;

endmodule

### sv/serial_frame_parser_xor_check.sv
`timescale 1ns / 1ps
// The first result of a frame follows its accepted end byte through the queue,
// a buffer read and the output register (no read for an empty frame). Each
// further byte takes a buffer read, then an output register load. Input bytes
// are taken one per cycle while the queue has room; a port stalls while its
// own frame is queued or in delivery. Reset puts every parser back to hunting.
// ----------------------------------------------------------------------------
// Serial frame parser with XOR check
// Per-port frame parsing of received bytes and delivery of the payload of
// every frame whose XOR checksum matches, with an APB register port.
// ----------------------------------------------------------------------------
module serial_frame_parser_xor_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Received bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_port_i,
  input  logic [7:0]  in_byte_i,
  // Delivered payload
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_port_o,
  output logic        out_command_o,
  output logic [6:0]  out_length_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        out_empty_o
);

  logic [7:0]                head_q, head_d;
  logic [7:0]                end_q, end_d;
  logic                      cfg_wr;
  logic                      q_full, q_valid, q_push, q_pop;
  sfp_pkg::sfp_desc_t        push_desc, pop_desc;
  sfp_pkg::sfp_wr_t          buf_wr;
  sfp_pkg::sfp_done_t        done;
  logic                      rd_en;
  logic [sfp_pkg::MemAW-1:0] rd_addr;
  logic [7:0]                rd_data;
  logic [sfp_pkg::Ports-1:0] busy;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    head_d = head_q;
    end_d  = end_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        sfp_pkg::RegHead: head_d = pwdata[7:0];
        sfp_pkg::RegEnd:  end_d  = pwdata[7:0];
        default:          head_d = head_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= sfp_pkg::HeadReset;
      end_q  <= sfp_pkg::EndReset;
    end else begin
      head_q <= head_d;
      end_q  <= end_d;
    end
  end

  assign prdata = {24'h000000, (paddr[2] == sfp_pkg::RegEnd) ? end_q : head_q};

  // Front parser.
  sfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_byte_i (head_q),
    .end_byte_i  (end_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_port_i   (in_port_i),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .desc_o      (push_desc),
    .wr_o        (buf_wr),
    .done_i      (done),
    .busy_o      (busy)
  );

  // Payload buffer shared by all ports.
  sfp_payload_buf u_buf (
    .clk_i     (clk_i),
    .wr_i      (buf_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Queue of checked frames.
  sfp_desc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_desc)
  );

  // Drain engine.
  sfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .desc_i        (pop_desc),
    .pop_o         (q_pop),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_port_o    (out_port_o),
    .out_command_o (out_command_o),
    .out_length_o  (out_length_o),
    .out_byte_o    (out_byte_o),
    .out_last_o    (out_last_o),
    .out_empty_o   (out_empty_o),
    .done_o        (done)
  );

  // A delivered frame always belongs to a port held busy by the front.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy[out_port_o])
    else $error("output transaction for a port that is not busy");

  // The queue never receives a frame while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("frame pushed into a full queue");

  // An empty-frame result is a single, final result of length zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_empty_o) |-> (out_last_o && (out_length_o == '0)))
    else $error("empty frame result is not final or has a length");

  // A port is released only by the taken last result of its frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done.valid |-> (out_valid_o && out_ready_i && out_last_o))
    else $error("port released before its last result was taken");

endmodule

### dv/frame_delivery_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame delivery checker
// Watches the register port and both byte channels of the serial frame
// parser. It tracks the frame parser of every port on its own, works out
// the payload bytes that each received byte releases, and compares every
// delivered transaction against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module frame_delivery_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Register port, observed only
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // Received byte channel
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        in_port_i,
  input  logic [7:0]  in_byte_i,
  // Delivered payload channel
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        out_port_i,
  input  logic        out_command_i,
  input  logic [6:0]  out_length_i,
  input  logic [7:0]  out_byte_i,
  input  logic        out_last_i,
  input  logic        out_empty_i,
  // Status handed to the testbench top
  output int          errors_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    StepHunt,
    StepCmd,
    StepLen,
    StepData,
    StepCheck,
    StepTail
  } parse_step_e;

  typedef struct packed {
    logic                     port;
    logic                     command;
    logic [sfp_pkg::LenW-1:0] length;
    logic [7:0]               data;
    logic                     is_last;
    logic                     is_empty;
  } delivered_beat_t;

  // Shadow copy of the registers.
  logic [7:0] head_q;
  logic [7:0] end_q;

  // Shadow copy of every port parser.
  parse_step_e              step_q   [sfp_pkg::Ports];
  logic [sfp_pkg::LenW-1:0] count_q  [sfp_pkg::Ports];
  logic [sfp_pkg::LenW-1:0] len_q    [sfp_pkg::Ports];
  logic [7:0]               sum_q    [sfp_pkg::Ports];
  logic [7:0]               check_q  [sfp_pkg::Ports];
  logic                     cmd_q    [sfp_pkg::Ports];
  logic [7:0]               payload_q[sfp_pkg::Ports][sfp_pkg::BufferDepth];

  delivered_beat_t expected_beats[$];
  int              mismatch_count;

  function automatic void clear_frame(int p);
    count_q[p] = '0;
    len_q[p]   = '0;
    sum_q[p]   = '0;
    check_q[p] = '0;
    cmd_q[p]   = 1'b0;
  endfunction

  // Advance the parser of one port by one byte and queue what it delivers.
  task automatic parse_rx_byte(input logic port, input logic [7:0] b);
    int              p;
    int              len;
    int              k;
    delivered_beat_t beat;
    p = int'(port);
    if (p >= sfp_pkg::Ports) return;
    case (step_q[p])
      StepHunt: begin
        if (b == head_q) begin
          clear_frame(p);
          step_q[p] = StepCmd;
        end
      end
      StepCmd: begin
        // Command codes win over a head byte of the same value.
        if (b == sfp_pkg::CmdF1 || b == sfp_pkg::CmdF2) begin
          cmd_q[p]  = (b == sfp_pkg::CmdF2);
          step_q[p] = StepLen;
        end else if (b == head_q) begin
          step_q[p] = StepCmd;
        end else begin
          step_q[p] = StepHunt;
        end
      end
      StepLen: begin
        if (int'(b) > sfp_pkg::BufferDepth) begin
          step_q[p] = StepHunt;
        end else begin
          len_q[p]  = sfp_pkg::LenW'(b);
          step_q[p] = (b == 8'd0) ? StepTail : StepData;
        end
      end
      StepData: begin
        if (int'(count_q[p]) < sfp_pkg::BufferDepth) begin
          payload_q[p][count_q[p]] = b;
          sum_q[p]   = sum_q[p] ^ b;
          count_q[p] = count_q[p] + 1'b1;
        end
        if (count_q[p] >= len_q[p]) step_q[p] = StepCheck;
      end
      StepCheck: begin
        check_q[p] = b;
        step_q[p]  = StepTail;
      end
      StepTail: begin
        // A head byte here restarts the frame; it is checked before the end byte.
        if (b == head_q) begin
          clear_frame(p);
          step_q[p] = StepCmd;
        end else begin
          if (b == end_q && sum_q[p] == check_q[p]) begin
            len = (int'(len_q[p]) > sfp_pkg::BufferDepth) ? sfp_pkg::BufferDepth
                                                          : int'(len_q[p]);
            if (len == 0) begin
              beat = '{port: port, command: cmd_q[p], length: '0, data: 8'h00,
                       is_last: 1'b1, is_empty: 1'b1};
              expected_beats.push_back(beat);
            end else begin
              for (k = 0; k < len; k++) begin
                beat = '{port: port, command: cmd_q[p], length: sfp_pkg::LenW'(len),
                         data: payload_q[p][k], is_last: (k + 1 == len),
                         is_empty: 1'b0};
                expected_beats.push_back(beat);
              end
            end
          end
          step_q[p] = StepHunt;
        end
      end
      default: begin
        step_q[p] = StepHunt;
      end
    endcase
  endtask

  // Compare one delivered transaction against the oldest expectation.
  task automatic check_beat();
    delivered_beat_t got;
    delivered_beat_t exp;
    got = '{port: out_port_i, command: out_command_i, length: out_length_i,
            data: out_byte_i, is_last: out_last_i, is_empty: out_empty_i};
    if (expected_beats.size() == 0) begin
      if (mismatch_count < 10) begin
        $display("[%0t] unexpected: port=%0d cmd=%0d len=%0d byte=%02h last=%0d empty=%0d",
                 $realtime, got.port, got.command, got.length, got.data, got.is_last,
                 got.is_empty);
      end
      mismatch_count++;
    end else begin
      exp = expected_beats.pop_front();
      if (got !== exp) begin
        if (mismatch_count < 10) begin
          $display("[%0t] expected port=%0d cmd=%0d len=%0d byte=%02h last=%0d empty=%0d",
                   $realtime, exp.port, exp.command, exp.length, exp.data, exp.is_last,
                   exp.is_empty);
          $display("[%0t]   actual port=%0d cmd=%0d len=%0d byte=%02h last=%0d empty=%0d",
                   $realtime, got.port, got.command, got.length, got.data, got.is_last,
                   got.is_empty);
        end
        mismatch_count++;
      end
    end
  endtask

  // Sample every channel at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q = sfp_pkg::HeadReset;
      end_q  = sfp_pkg::EndReset;
      for (int p = 0; p < sfp_pkg::Ports; p++) begin
        step_q[p] = StepHunt;
        clear_frame(p);
        for (int i = 0; i < sfp_pkg::BufferDepth; i++) payload_q[p][i] = 8'h00;
      end
      expected_beats.delete();
      mismatch_count = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_beat();
      if (in_valid_i && in_ready_i) parse_rx_byte(in_port_i, in_byte_i);
      // A register write takes effect after the bytes taken at this edge.
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == sfp_pkg::RegHead) head_q = pwdata[7:0];
        else end_q = pwdata[7:0];
      end
      errors_o  <= mismatch_count;
      pending_o <= expected_beats.size();
    end
  end

endmodule

### dv/serial_frame_parser_xor_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame parser testbench
// Drives framed byte streams on both ports through several head and end
// byte settings, with random gaps on both channels and one long receiver
// hold-off, and reports the verdict from the frame delivery checker.
// ----------------------------------------------------------------------------
module serial_frame_parser_xor_check_tb;

  localparam int ClkHalf    = 6;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int DrainGap   = 12;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic        in_port_i     = 1'b0;
  logic [7:0]  in_byte_i     = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic        out_port_o;
  logic        out_command_o;
  logic [6:0]  out_length_o;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic        out_empty_o;

  int          check_errors;
  int          check_pending;
  int          cycle_count   = 0;
  bit          quiet         = 1'b0;
  bit          hold_req      = 1'b0;
  logic [7:0]  head_cfg      = sfp_pkg::HeadReset;
  logic [7:0]  end_cfg       = sfp_pkg::EndReset;

  // Per-port byte streams waiting to be sent.
  logic [7:0]  lane0_q[$];
  logic [7:0]  lane1_q[$];

  serial_frame_parser_xor_check DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_port_i     (in_port_i),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_port_o    (out_port_o),
    .out_command_o (out_command_o),
    .out_length_o  (out_length_o),
    .out_byte_o    (out_byte_o),
    .out_last_o    (out_last_o),
    .out_empty_o   (out_empty_o)
  );

  frame_delivery_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_port_i     (in_port_i),
    .in_byte_i     (in_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_port_i    (out_port_o),
    .out_command_i (out_command_o),
    .out_length_i  (out_length_o),
    .out_byte_i    (out_byte_o),
    .out_last_i    (out_last_o),
    .out_empty_i   (out_empty_o),
    .errors_o      (check_errors),
    .pending_o     (check_pending)
  );

  // Clock generation.
  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver side: random stalls, one long hold-off on request.
  initial begin : receiver
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 5);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Register write: setup cycle, access cycle until pready, then a return to idle.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one byte, after an optional gap, and hold it until the transaction.
  task automatic send_byte(input logic port, input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_port_i  <= port;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic lane_push(input logic port, input logic [7:0] b);
    if (port) lane1_q.push_back(b);
    else lane0_q.push_back(b);
  endtask

  // Send both lanes, interleaving the ports at random.
  task automatic play_lanes();
    logic port;
    while (lane0_q.size() != 0 || lane1_q.size() != 0) begin
      if (lane0_q.size() == 0) port = 1'b1;
      else if (lane1_q.size() == 0) port = 1'b0;
      else port = 1'($urandom_range(0, 1));
      if (port) send_byte(1'b1, lane1_q.pop_front());
      else send_byte(1'b0, lane0_q.pop_front());
    end
  endtask

  // Command, length, payload and checksum of one frame.
  task automatic queue_body(input logic port, input int len, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    sum = 8'h00;
    lane_push(port, ($urandom_range(0, 1) != 0) ? sfp_pkg::CmdF2 : sfp_pkg::CmdF1);
    lane_push(port, 8'(len));
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      sum = sum ^ b;
      lane_push(port, b);
    end
    if (len != 0) lane_push(port, good_sum ? sum : (sum ^ 8'($urandom_range(1, 255))));
  endtask

  // One random frame: mostly well formed, the rest broken or noise.
  task automatic queue_frame(input logic port, input int len);
    int         kind;
    int         i;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      lane_push(port, head_cfg);
      queue_body(port, len, 1'b1);
      lane_push(port, end_cfg);
    end else if (kind < 72) begin
      // Checksum does not match the payload.
      lane_push(port, head_cfg);
      queue_body(port, len, 1'b0);
      lane_push(port, end_cfg);
    end else if (kind < 78) begin
      // Length beyond the buffer.
      lane_push(port, head_cfg);
      lane_push(port, sfp_pkg::CmdF1);
      lane_push(port, 8'($urandom_range(sfp_pkg::BufferDepth + 1, 255)));
    end else if (kind < 83) begin
      // Unknown command byte.
      lane_push(port, head_cfg);
      do b = 8'($urandom_range(0, 255));
      while (b == sfp_pkg::CmdF1 || b == sfp_pkg::CmdF2 || b == head_cfg);
      lane_push(port, b);
    end else if (kind < 88) begin
      // Stray byte where the end byte belongs.
      lane_push(port, head_cfg);
      queue_body(port, len, 1'b1);
      do b = 8'($urandom_range(0, 255));
      while (b == end_cfg || b == head_cfg);
      lane_push(port, b);
    end else if (kind < 93) begin
      // Head byte in the end state restarts the frame.
      lane_push(port, head_cfg);
      queue_body(port, len, 1'b1);
      lane_push(port, head_cfg);
      queue_body(port, $urandom_range(0, 6), 1'b1);
      lane_push(port, end_cfg);
    end else if (kind < 97) begin
      // Frame cut short; following bytes land in its payload.
      lane_push(port, head_cfg);
      lane_push(port, sfp_pkg::CmdF2);
      lane_push(port, 8'(len + 2));
      for (i = 0; i < len; i++) lane_push(port, 8'($urandom_range(0, 255)));
    end else begin
      for (i = 0; i < $urandom_range(1, 4); i++) lane_push(port, 8'($urandom_range(0, 255)));
    end
  endtask

  // Queue random frames on both ports until the byte budget is reached.
  task automatic random_traffic(input int budget);
    int len;
    while (lane0_q.size() + lane1_q.size() < budget) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(9, sfp_pkg::BufferDepth)
                                         : $urandom_range(0, 8);
      queue_frame(1'($urandom_range(0, 1)), len);
    end
    play_lanes();
  endtask

  // Let the block go idle: nothing outstanding, then the DrainGap margin.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (check_pending != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  task automatic set_frame_bytes(input logic [7:0] hb, input logic [7:0] eb);
    write_reg(sfp_pkg::RegHead, hb);
    write_reg(sfp_pkg::RegEnd, eb);
    head_cfg = hb;
    end_cfg  = eb;
  endtask

  // Main stimulus.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames with the reset head and end bytes.
    // Empty frame.
    lane_push(1'b0, 8'hAA); lane_push(1'b0, sfp_pkg::CmdF1); lane_push(1'b0, 8'h00);
    lane_push(1'b0, 8'h55);
    // Repeated head while a command is awaited, all-ones payload on port 1.
    lane_push(1'b1, 8'hAA); lane_push(1'b1, 8'hAA); lane_push(1'b1, sfp_pkg::CmdF2);
    lane_push(1'b1, 8'h01); lane_push(1'b1, 8'hFF); lane_push(1'b1, 8'hFF);
    lane_push(1'b1, 8'h55);
    // Length one above the buffer.
    lane_push(1'b0, 8'hAA); lane_push(1'b0, sfp_pkg::CmdF1); lane_push(1'b0, 8'h41);
    // Checksum mismatch.
    lane_push(1'b0, 8'hAA); lane_push(1'b0, sfp_pkg::CmdF1); lane_push(1'b0, 8'h01);
    lane_push(1'b0, 8'h00); lane_push(1'b0, 8'h01); lane_push(1'b0, 8'h55);
    // Head in the end state, then an empty frame completes.
    lane_push(1'b0, 8'hAA); lane_push(1'b0, sfp_pkg::CmdF1); lane_push(1'b0, 8'h00);
    lane_push(1'b0, 8'hAA); lane_push(1'b0, sfp_pkg::CmdF2); lane_push(1'b0, 8'h00);
    lane_push(1'b0, 8'h55);
    play_lanes();

    // Full-buffer frame while the receiver holds off, then random traffic.
    hold_req = 1'b1;
    lane_push(1'b1, head_cfg);
    queue_body(1'b1, sfp_pkg::BufferDepth, 1'b1);
    lane_push(1'b1, end_cfg);
    random_traffic(72);
    wait_idle();

    // Register extremes and collisions with the command codes.
    set_frame_bytes(8'h00, 8'hFF);
    random_traffic(10);
    wait_idle();
    set_frame_bytes(8'hFF, 8'h00);
    random_traffic(10);
    wait_idle();
    set_frame_bytes(sfp_pkg::CmdF1, sfp_pkg::CmdF1);
    random_traffic(10);
    wait_idle();
    set_frame_bytes(sfp_pkg::CmdF2, 8'h55);
    random_traffic(10);
    wait_idle();

    // Last part runs without gaps.
    quiet = 1'b1;
    set_frame_bytes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_traffic(10);
    wait_idle();

    if (check_errors == 0 && check_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
